FILE: hdl/das_pkg.sv
// Deferred action scheduler: shared types and constants.
// Used by das_ctrl, das_dp, the top level and the port checker.
// No dependencies.
package das_pkg;

	localparam int CODE_W         = 3;
	localparam int HANDLE_W       = 16;
	localparam int TIME_W         = 32;
	localparam int NUM_DELAY_REGS = 8;
	localparam int DLY_IDX_W      = 3;
	localparam int CFG_IDX_W      = 4;

	// Result event codes
	typedef enum logic [2:0] {
		EV_QUEUED     = 3'd0,
		EV_ARMED      = 3'd1,
		EV_ALREADY    = 3'd2,
		EV_DROPPED    = 3'd3,
		EV_FIRED      = 3'd4,
		EV_DISPATCHED = 3'd5,
		EV_NOTHING    = 3'd6
	} ev_kind_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN,
		ST_FIRE,
		ST_DISP
	} das_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;
		logic add;
		logic scan;
		logic fire;
		logic dispatch;
	} das_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_last;
		logic scan_any;
		logic fire_rest_zero;
		logic q_empty;
	} das_sts_t;

endpackage

FILE: hdl/deferred_action_scheduler.sv
// Deferred action scheduler: top level joining controller and datapath.
// Depends on das_pkg, das_ctrl and das_dp.
//
// Usage:
//   Requests enter on start/busy: a request is taken at a clock edge with
//   start high and busy low. action 0 is an add, action 1 a poll tick.
//   Results leave one per cycle on result_valid with their fields; the
//   receiver cannot hold them off. last_of_run marks a request's final result.
//   Delay registers are written on cfg_valid/cfg_ready, ready always high, by
//   users only while idle (not enforced); indexes past the eight are ignored.
// Sequence:
//   add: busy for 1 cycle; its one result shows in the cycle busy falls.
//   poll: scans the NUM_ACTIONS timers (one timer compare per cycle), then
//   fires each collected timer, then takes the queue head, a step skipped
//   when timers fired and the queue is empty. The result of the last step
//   shows in the cycle busy falls.
// Reset:
//   arst_n clears delays, armed timers and the queue pointers.
module deferred_action_scheduler #(
	parameter int NUM_ACTIONS = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [das_pkg::CODE_W-1:0]    action_code,
	input  logic [das_pkg::HANDLE_W-1:0]  image_handle,
	input  logic [das_pkg::HANDLE_W-1:0]  list_handle,
	input  logic [das_pkg::TIME_W-1:0]    now_ms,
	input  logic                          force_all,
	// configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [das_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [das_pkg::TIME_W-1:0]    cfg_data,
	// result channel
	output logic                          result_valid,
	output logic [2:0]                    event_kind,
	output logic [das_pkg::CODE_W-1:0]    out_action_code,
	output logic [das_pkg::HANDLE_W-1:0]  out_image_handle,
	output logic [das_pkg::HANDLE_W-1:0]  out_list_handle,
	output logic                          last_of_run
);

	das_pkg::das_cmd_t cmd;
	das_pkg::das_sts_t sts;

	assign cfg_ready = 1'b1;

	das_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	das_dp #(
		.NUM_ACTIONS (NUM_ACTIONS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.action           (action),
		.action_code      (action_code),
		.image_handle     (image_handle),
		.list_handle      (list_handle),
		.now_ms           (now_ms),
		.force_all        (force_all),
		.cfg_wr           (cfg_valid & cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.event_kind       (event_kind),
		.out_action_code  (out_action_code),
		.out_image_handle (out_image_handle),
		.out_list_handle  (out_list_handle),
		.last_of_run      (last_of_run)
	);

endmodule

FILE: hdl/das_ctrl.sv
// Deferred action scheduler: sequencing state machine.
// Depends on das_pkg (states, command and status structs).
module das_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               action,
	input  das_pkg::das_sts_t  sts,
	output das_pkg::das_cmd_t  cmd,
	output logic               busy
);

	das_pkg::das_state_t state_q;
	das_pkg::das_state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= das_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			das_pkg::ST_IDLE: begin
				if (start) begin
					state_nx = action ? das_pkg::ST_SCAN : das_pkg::ST_ADD;
				end
			end
			das_pkg::ST_ADD: begin
				state_nx = das_pkg::ST_IDLE;
			end
			das_pkg::ST_SCAN: begin
				// scan done: fire collected timers, else go straight to the queue
				if (sts.scan_last) begin
					state_nx = sts.scan_any ? das_pkg::ST_FIRE : das_pkg::ST_DISP;
				end
			end
			das_pkg::ST_FIRE: begin
				if (sts.fire_rest_zero) begin
					state_nx = sts.q_empty ? das_pkg::ST_IDLE : das_pkg::ST_DISP;
				end
			end
			das_pkg::ST_DISP: begin
				state_nx = das_pkg::ST_IDLE;
			end
			default: begin
				state_nx = das_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			das_pkg::ST_IDLE: begin
				busy      = 1'b0;
				cmd.latch = start;
			end
			das_pkg::ST_ADD:  cmd.add      = 1'b1;
			das_pkg::ST_SCAN: cmd.scan     = 1'b1;
			das_pkg::ST_FIRE: cmd.fire     = 1'b1;
			das_pkg::ST_DISP: cmd.dispatch = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

FILE: hdl/das_dp.sv
// Deferred action scheduler: datapath with delay registers, timers,
// action queue memory and result register. Depends on das_pkg.
module das_dp #(
	parameter int NUM_ACTIONS = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  das_pkg::das_cmd_t                     cmd,
	output das_pkg::das_sts_t                     sts,
	// request fields
	input  logic                                  action,
	input  logic [das_pkg::CODE_W-1:0]            action_code,
	input  logic [das_pkg::HANDLE_W-1:0]          image_handle,
	input  logic [das_pkg::HANDLE_W-1:0]          list_handle,
	input  logic [das_pkg::TIME_W-1:0]            now_ms,
	input  logic                                  force_all,
	// configuration writes
	input  logic                                  cfg_wr,
	input  logic [das_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [das_pkg::TIME_W-1:0]            cfg_data,
	// result
	output logic                                  result_valid,
	output logic [2:0]                            event_kind,
	output logic [das_pkg::CODE_W-1:0]            out_action_code,
	output logic [das_pkg::HANDLE_W-1:0]          out_image_handle,
	output logic [das_pkg::HANDLE_W-1:0]          out_list_handle,
	output logic                                  last_of_run
);

	localparam int AW   = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
	localparam int QW   = $clog2(QUEUE_DEPTH);
	localparam int QE_W = das_pkg::CODE_W + 2 * das_pkg::HANDLE_W;
	localparam logic [das_pkg::CODE_W:0] NA_LIM = (das_pkg::CODE_W + 1)'(NUM_ACTIONS);

	// configuration
	logic [das_pkg::TIME_W-1:0]   delay_q [das_pkg::NUM_DELAY_REGS];
	// latched request
	logic                         is_poll_q;
	logic [das_pkg::CODE_W-1:0]   code_q;
	logic [das_pkg::HANDLE_W-1:0] img_q;
	logic [das_pkg::HANDLE_W-1:0] lst_q;
	logic [das_pkg::TIME_W-1:0]   now_q;
	logic                         force_q;
	// timers
	logic [NUM_ACTIONS-1:0]       armed_q;
	logic [das_pkg::TIME_W-1:0]   deadline_q [NUM_ACTIONS];
	logic [NUM_ACTIONS-1:0]       mask_q;
	logic [AW-1:0]                idx_q;
	// queue
	logic [QE_W-1:0]              mem [QUEUE_DEPTH];
	logic [QE_W-1:0]              rd_q;
	logic [QW-1:0]                wp_q;
	logic [QW-1:0]                rp_q;

	logic [das_pkg::CODE_W-1:0]   rd_code;
	logic [das_pkg::HANDLE_W-1:0] rd_img;
	logic [das_pkg::HANDLE_W-1:0] rd_lst;
	logic [das_pkg::CODE_W-1:0]   sel_code;
	logic [AW-1:0]                sel_idx;
	logic [das_pkg::TIME_W-1:0]   sel_delay;
	logic                         has_delay;
	logic                         sel_armed;
	logic                         do_arm;
	logic                         scan_hit;
	logic [NUM_ACTIONS-1:0]       scan_bit;
	logic [NUM_ACTIONS-1:0]       mask_nx;
	logic [AW-1:0]                fire_idx;
	logic [NUM_ACTIONS-1:0]       mask_rest;
	logic                         q_empty;
	logic                         q_full;
	logic [QW-1:0]                wp_nx;
	logic [QW-1:0]                rp_nx;
	logic                         push;
	logic                         pop;
	logic                         emit;
	das_pkg::ev_kind_t            ev_d;
	logic [das_pkg::CODE_W-1:0]   code_d;
	logic [das_pkg::HANDLE_W-1:0] img_d;
	logic [das_pkg::HANDLE_W-1:0] lst_d;
	logic                         last_d;
	logic                         result_valid_q;
	logic [2:0]                   ev_q;
	logic [das_pkg::CODE_W-1:0]   out_code_q;
	logic [das_pkg::HANDLE_W-1:0] out_img_q;
	logic [das_pkg::HANDLE_W-1:0] out_lst_q;
	logic                         last_q;

	assign {rd_code, rd_img, rd_lst} = rd_q;

	// Delay lookup for the add code or the dequeued code
	assign sel_code  = cmd.dispatch ? rd_code : code_q;
	assign sel_idx   = sel_code[AW-1:0];
	assign sel_delay = delay_q[sel_code];
	assign has_delay = ({1'b0, sel_code} < NA_LIM) && (sel_delay != '0);
	assign sel_armed = armed_q[sel_idx];

	// Queue pointers
	assign q_empty = (wp_q == rp_q);
	assign wp_nx   = (wp_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_nx   = (rp_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign q_full  = (wp_nx == rp_q);
	assign push    = cmd.add && !has_delay && !q_full;
	assign pop     = cmd.dispatch && !q_empty;
	assign do_arm  = (cmd.add || pop) && has_delay && !sel_armed;

	// Timer scan, one timer per cycle
	assign scan_hit = armed_q[idx_q] && (force_q || (now_q >= deadline_q[idx_q]));
	assign scan_bit = scan_hit ? (NUM_ACTIONS'(1) << idx_q) : '0;
	assign mask_nx  = mask_q | scan_bit;

	// Lowest pending fire
	always_comb begin
		fire_idx = '0;
		for (int i = NUM_ACTIONS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				fire_idx = AW'(i);
			end
		end
	end
	assign mask_rest = mask_q & (mask_q - 1'b1);

	assign sts.scan_last      = (idx_q == AW'(NUM_ACTIONS - 1));
	assign sts.scan_any       = |mask_nx;
	assign sts.fire_rest_zero = (mask_rest == '0);
	assign sts.q_empty        = q_empty;

	// Result selection
	always_comb begin
		ev_d   = das_pkg::EV_NOTHING;
		code_d = '0;
		img_d  = '0;
		lst_d  = '0;
		last_d = 1'b1;
		if (cmd.fire) begin
			ev_d   = das_pkg::EV_FIRED;
			code_d = das_pkg::CODE_W'(fire_idx);
			last_d = (mask_rest == '0) && q_empty;
		end else if (cmd.add || pop) begin
			code_d = sel_code;
			if (has_delay) begin
				ev_d = sel_armed ? das_pkg::EV_ALREADY : das_pkg::EV_ARMED;
			end else if (pop) begin
				ev_d  = das_pkg::EV_DISPATCHED;
				img_d = rd_img;
				lst_d = rd_lst;
			end else begin
				ev_d = q_full ? das_pkg::EV_DROPPED : das_pkg::EV_QUEUED;
			end
		end
	end
	assign emit = cmd.add || cmd.fire || cmd.dispatch;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < das_pkg::NUM_DELAY_REGS; i++) begin
				delay_q[i] <= '0;
			end
		end else if (cfg_wr &&
			(cfg_index < das_pkg::CFG_IDX_W'(das_pkg::NUM_DELAY_REGS))) begin
			delay_q[cfg_index[das_pkg::DLY_IDX_W-1:0]] <= cfg_data;
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			is_poll_q <= action;
			code_q    <= action_code;
			img_q     <= image_handle;
			lst_q     <= list_handle;
			now_q     <= now_ms;
			force_q   <= force_all;
		end
	end

	// Armed flags, scan index and fire mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			mask_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.latch) begin
				mask_q <= '0;
				idx_q  <= '0;
			end
			if (cmd.scan && is_poll_q) begin
				mask_q <= mask_nx;
				idx_q  <= idx_q + 1'b1;
				if (scan_hit) begin
					armed_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.fire) begin
				mask_q <= mask_rest;
			end
			if (do_arm) begin
				armed_q[sel_idx] <= 1'b1;
			end
		end
	end

	// Deadlines
	always_ff @(posedge clk) begin
		if (do_arm) begin
			deadline_q[sel_idx] <= now_q + sel_delay;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_nx;
			end
			if (pop) begin
				rp_q <= rp_nx;
			end
		end
	end

	// Queue memory, registered read at the head
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= {code_q, img_q, lst_q};
		end
		rd_q <= mem[rp_q];
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ev_q       <= ev_d;
			out_code_q <= code_d;
			out_img_q  <= img_d;
			out_lst_q  <= lst_d;
			last_q     <= last_d;
		end
	end

	assign result_valid     = result_valid_q;
	assign event_kind       = ev_q;
	assign out_action_code  = out_code_q;
	assign out_image_handle = out_img_q;
	assign out_list_handle  = out_lst_q;
	assign last_of_run      = last_q;

endmodule

FILE: hdl/das_checker.sv
// Deferred action scheduler: port-level checks, bound to the top level.
// Depends on das_pkg (event codes) and deferred_action_scheduler.
module das_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         result_valid,
	input logic [2:0]                   event_kind,
	input logic [das_pkg::CODE_W-1:0]   out_action_code,
	input logic [das_pkg::HANDLE_W-1:0] out_image_handle,
	input logic [das_pkg::HANDLE_W-1:0] out_list_handle,
	input logic                         last_of_run
);

	// an accepted request always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// the final result shows exactly when the block goes idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (busy == !last_of_run))
		else $error("last_of_run out of step with busy");

	// handles only travel with a dispatched queue entry
	a_handles_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (event_kind != das_pkg::EV_DISPATCHED)
		|-> (out_image_handle == '0) && (out_list_handle == '0))
		else $error("handles nonzero on a non-dispatch result");

	// a quiet poll is a lone result for code zero
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (event_kind == das_pkg::EV_NOTHING)
		|-> last_of_run && (out_action_code == '0))
		else $error("malformed quiet poll result");

endmodule

bind deferred_action_scheduler das_checker u_das_checker (.*);
